// ----- rtl/tbbm_pkg.sv -----
// ----------------------------------------------------------------------------
// tbbm_pkg
// Shared types, codes and helpers for the text bounding box measurer.
// ----------------------------------------------------------------------------
package tbbm_pkg;

    localparam int GLYPH_COUNT = 95;
    localparam int GLYPH_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int COORD_BITS  = 16;
    localparam int WIDE_BITS   = COORD_BITS + 2;
    localparam int OUT_BITS    = 16;
    localparam int FIELD_BITS  = 6;
    localparam int HEIGHT_BITS = 8;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_MEASURE = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;

    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd126;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam int LINE_GAP_SHIFT = 2;

    localparam logic CFG_FONT_HEIGHT  = 1'b0;
    localparam logic CFG_ADVANCE_ONLY = 1'b1;

    localparam logic [HEIGHT_BITS-1:0] FONT_HEIGHT_RESET = 8'd16;

    typedef struct packed {
        logic        [FIELD_BITS-1:0] advance;
        logic signed [FIELD_BITS-1:0] y_shift;
        logic signed [FIELD_BITS-1:0] x_shift;
        logic        [FIELD_BITS-1:0] width;
    } metrics_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_GLYPH,
        OP_NEWLINE,
        OP_END
    } op_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] top;
        logic signed [OUT_BITS-1:0] right;
        logic signed [OUT_BITS-1:0] bottom;
    } box_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
        begin
            return hi[COORD_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_BITS-1:0];
        end
        else
        begin
            return v[COORD_BITS-1:0];
        end
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] widen(
        input logic signed [COORD_BITS-1:0] v
    );
        return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

endpackage

// ----- rtl/tbbm_glyph_table.sv -----
// ----------------------------------------------------------------------------
// tbbm_glyph_table
// Glyph metrics memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbbm_glyph_table (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [tbbm_pkg::GLYPH_AW-1:0] wr_addr,
    input  tbbm_pkg::metrics_t           wr_data,
    input  logic                         rd_en,
    input  logic [tbbm_pkg::GLYPH_AW-1:0] rd_addr,
    output tbbm_pkg::metrics_t           rd_data
);

    tbbm_pkg::metrics_t mem [tbbm_pkg::GLYPH_COUNT];
    tbbm_pkg::metrics_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tbbm_measure_core.sv -----
// ----------------------------------------------------------------------------
// tbbm_measure_core
// Per-string pen and extent state, updated once per retired request.
// ----------------------------------------------------------------------------
module tbbm_measure_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  tbbm_pkg::op_t                       op,
    input  tbbm_pkg::metrics_t                  metrics,
    input  logic [tbbm_pkg::HEIGHT_BITS-1:0]    font_height,
    input  logic                                advance_only,
    output tbbm_pkg::box_t                      box
);

    localparam int C = tbbm_pkg::COORD_BITS;
    localparam int W = tbbm_pkg::WIDE_BITS;
    localparam int F = tbbm_pkg::FIELD_BITS;
    localparam int H = tbbm_pkg::HEIGHT_BITS;

    logic signed [C-1:0] pen_x_reg, pen_x_next;
    logic signed [C-1:0] pen_y_reg, pen_y_next;
    logic signed [C-1:0] ext_left_reg, ext_left_next;
    logic signed [C-1:0] ext_top_reg, ext_top_next;
    logic signed [C-1:0] ext_bottom_reg, ext_bottom_next;
    logic signed [C-1:0] widest_reg, widest_next;
    logic signed [C-1:0] line_adv_reg, line_adv_next;
    logic signed [C-1:0] line_drawn_reg, line_drawn_next;
    logic signed [C-1:0] overflow_reg, overflow_next;

    logic signed [W-1:0] xs_w, ys_w, width_w, adv_w, height_w, gap_w;
    logic signed [W-1:0] px_w, py_w;
    logic signed [C-1:0] drawn_right, glyph_bottom, glyph_left, glyph_top, pen_adv;
    logic signed [C-1:0] nl_pen_y, line_ov, overflow_closed, right_sum;

    assign xs_w     = {{(W-F){metrics.x_shift[F-1]}}, metrics.x_shift};
    assign ys_w     = {{(W-F){metrics.y_shift[F-1]}}, metrics.y_shift};
    assign width_w  = {{(W-F){1'b0}}, metrics.width};
    assign adv_w    = {{(W-F){1'b0}}, metrics.advance};
    assign height_w = {{(W-H){1'b0}}, font_height};
    assign gap_w    = height_w >>> tbbm_pkg::LINE_GAP_SHIFT;
    assign px_w     = tbbm_pkg::widen(pen_x_reg);
    assign py_w     = tbbm_pkg::widen(pen_y_reg);

    assign drawn_right  = tbbm_pkg::sat_coord(px_w + xs_w + width_w);
    assign glyph_bottom = tbbm_pkg::sat_coord(py_w + ys_w + height_w);
    assign glyph_left   = tbbm_pkg::sat_coord(px_w + xs_w);
    assign glyph_top    = tbbm_pkg::sat_coord(py_w + ys_w);
    assign pen_adv      = tbbm_pkg::sat_coord(px_w + xs_w + adv_w);
    assign nl_pen_y     = tbbm_pkg::sat_coord(py_w + height_w + gap_w);

    // overflow of the line being closed
    assign line_ov = tbbm_pkg::sat_coord(tbbm_pkg::widen(line_drawn_reg)
                                         - tbbm_pkg::widen(line_adv_reg));
    assign overflow_closed = (line_ov > overflow_reg) ? line_ov : overflow_reg;
    assign right_sum = tbbm_pkg::sat_coord(tbbm_pkg::widen(widest_reg)
                                           + tbbm_pkg::widen(overflow_closed));

    always_comb
    begin
        box.left   = advance_only ? '0 : tbbm_pkg::OUT_BITS'(ext_left_reg);
        box.top    = tbbm_pkg::OUT_BITS'(ext_top_reg);
        box.right  = advance_only ? tbbm_pkg::OUT_BITS'(widest_reg)
                                  : tbbm_pkg::OUT_BITS'(right_sum);
        box.bottom = tbbm_pkg::OUT_BITS'(ext_bottom_reg);
    end

    always_comb
    begin
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        ext_left_next   = ext_left_reg;
        ext_top_next    = ext_top_reg;
        ext_bottom_next = ext_bottom_reg;
        widest_next     = widest_reg;
        line_adv_next   = line_adv_reg;
        line_drawn_next = line_drawn_reg;
        overflow_next   = overflow_reg;
        case (op)
            tbbm_pkg::OP_GLYPH:
            begin
                if (drawn_right > line_drawn_reg)
                begin
                    line_drawn_next = drawn_right;
                end
                if (glyph_bottom > ext_bottom_reg)
                begin
                    ext_bottom_next = glyph_bottom;
                end
                if (glyph_left < ext_left_reg)
                begin
                    ext_left_next = glyph_left;
                end
                if (glyph_top < ext_top_reg)
                begin
                    ext_top_next = glyph_top;
                end
                pen_x_next = pen_adv;
                if (pen_adv > widest_reg)
                begin
                    widest_next = pen_adv;
                end
                if (pen_adv > line_adv_reg)
                begin
                    line_adv_next = pen_adv;
                end
            end
            tbbm_pkg::OP_NEWLINE:
            begin
                pen_y_next = nl_pen_y;
                pen_x_next = '0;
                if (nl_pen_y > ext_bottom_reg)
                begin
                    ext_bottom_next = nl_pen_y;
                end
                overflow_next   = overflow_closed;
                line_adv_next   = '0;
                line_drawn_next = '0;
            end
            tbbm_pkg::OP_END:
            begin
                pen_x_next      = '0;
                pen_y_next      = '0;
                ext_left_next   = '0;
                ext_top_next    = '0;
                ext_bottom_next = '0;
                widest_next     = '0;
                line_adv_next   = '0;
                line_drawn_next = '0;
                overflow_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            ext_left_reg   <= '0;
            ext_top_reg    <= '0;
            ext_bottom_reg <= '0;
            widest_reg     <= '0;
            line_adv_reg   <= '0;
            line_drawn_reg <= '0;
            overflow_reg   <= '0;
        end
        else if (step_en)
        begin
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            ext_left_reg   <= ext_left_next;
            ext_top_reg    <= ext_top_next;
            ext_bottom_reg <= ext_bottom_next;
            widest_reg     <= widest_next;
            line_adv_reg   <= line_adv_next;
            line_drawn_reg <= line_drawn_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule

// ----- rtl/text_bounding_box_measurer.sv -----
// ----------------------------------------------------------------------------
// text_bounding_box_measurer
// Measures the pixel bounding box of a text string one character at a time.
// ----------------------------------------------------------------------------
// One request is accepted per clock unless the input stalls. Glyph loads
// write the metrics table in the accept cycle; a character reads its table
// entry in the accept cycle and updates the pen and extent registers in the
// next cycle, so a new character can follow every cycle. An end-of-string
// request passes the stage register and delivers its box from the output
// register. Input stalls only while a box waits in the output register and
// the next end-of-string request is ready to retire. The user writes the font
// height and advance-only flag only while idle (not enforced by the block).
module text_bounding_box_measurer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [6:0]         glyph_index,
    input  logic [7:0]         char_code,
    input  logic [5:0]         glyph_width,
    input  logic signed [5:0]  glyph_x_shift,
    input  logic signed [5:0]  glyph_y_shift,
    input  logic [5:0]         glyph_advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] box_left,
    output logic signed [15:0] box_top,
    output logic signed [15:0] box_right,
    output logic signed [15:0] box_bottom
);

    localparam int AW = tbbm_pkg::GLYPH_AW;

    logic [tbbm_pkg::HEIGHT_BITS-1:0] font_height_reg;
    logic                             advance_only_reg;

    logic               accept;
    logic [7:0]         entry;
    logic               is_printable, is_newline, load_ok;
    tbbm_pkg::metrics_t wr_metrics, rd_metrics;
    tbbm_pkg::op_t      op_in;

    logic               s_valid_reg, s_valid_next;
    tbbm_pkg::op_t      s_op_reg;
    logic               stall, step_en;

    tbbm_pkg::box_t     box_result, box_reg;
    logic               out_valid_reg, out_valid_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_height_reg  <= tbbm_pkg::FONT_HEIGHT_RESET;
            advance_only_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                tbbm_pkg::CFG_FONT_HEIGHT:  font_height_reg  <= cfg_data;
                tbbm_pkg::CFG_ADVANCE_ONLY: advance_only_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // request decode
    assign accept = in_valid && in_ready;
    assign entry  = char_code - tbbm_pkg::CHAR_FIRST;
    assign is_printable = (char_code >= tbbm_pkg::CHAR_FIRST)
                       && (char_code <= tbbm_pkg::CHAR_LAST)
                       && (9'(entry) < 9'(tbbm_pkg::GLYPH_COUNT));
    assign is_newline = (char_code == tbbm_pkg::CHAR_NEWLINE);
    assign load_ok    = (9'(glyph_index) < 9'(tbbm_pkg::GLYPH_COUNT));

    always_comb
    begin
        case (mode)
            tbbm_pkg::MODE_MEASURE:
            begin
                if (is_printable)
                begin
                    op_in = tbbm_pkg::OP_GLYPH;
                end
                else if (is_newline)
                begin
                    op_in = tbbm_pkg::OP_NEWLINE;
                end
                else
                begin
                    op_in = tbbm_pkg::OP_NOP;
                end
            end
            tbbm_pkg::MODE_END: op_in = tbbm_pkg::OP_END;
            default:            op_in = tbbm_pkg::OP_NOP;
        endcase
    end

    assign wr_metrics.advance = glyph_advance;
    assign wr_metrics.y_shift = glyph_y_shift;
    assign wr_metrics.x_shift = glyph_x_shift;
    assign wr_metrics.width   = glyph_width;

    tbbm_glyph_table u_table (
        .clk     (clk),
        .wr_en   (accept && (mode == tbbm_pkg::MODE_LOAD) && load_ok),
        .wr_addr (AW'(glyph_index)),
        .wr_data (wr_metrics),
        .rd_en   (accept && (op_in == tbbm_pkg::OP_GLYPH)),
        .rd_addr (AW'(entry)),
        .rd_data (rd_metrics)
    );

    // stage register
    assign stall    = s_valid_reg && (s_op_reg == tbbm_pkg::OP_END)
                   && out_valid_reg && !out_ready;
    assign step_en  = s_valid_reg && !stall;
    assign in_ready = !stall;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            s_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            s_op_reg    <= tbbm_pkg::OP_NOP;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (accept)
            begin
                s_op_reg <= op_in;
            end
        end
    end

    tbbm_measure_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .op           (s_op_reg),
        .metrics      (rd_metrics),
        .font_height  (font_height_reg),
        .advance_only (advance_only_reg),
        .box          (box_result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en && (s_op_reg == tbbm_pkg::OP_END))
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && (s_op_reg == tbbm_pkg::OP_END))
        begin
            box_reg <= box_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign box_left   = box_reg.left;
    assign box_top    = box_reg.top;
    assign box_right  = box_reg.right;
    assign box_bottom = box_reg.bottom;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text bounding box measurer.
// ----------------------------------------------------------------------------
// Glyph loads, characters and end-of-string requests go in over a valid/ready
// channel with random gaps, and the boxes come back under random output
// stalls. A local model of the pen, the extents and the glyph table predicts
// every box, which is compared field by field in arrival order. Tests cover
// field extremes, ignored codes, coordinate saturation, a long output hold
// that backs up the input, and random strings under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import tbbm_pkg::*;

    localparam int         CLK_PERIOD     = 20;
    localparam int         RESET_CYCLES   = 12;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         MAX_REPORTS    = 10;
    localparam int         PHASE_REQUESTS = 10;
    localparam int         SETTING_COUNT  = 6;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic               cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [6:0]         glyph_index;
    logic [7:0]         char_code;
    logic [5:0]         glyph_width;
    logic signed [5:0]  glyph_x_shift;
    logic signed [5:0]  glyph_y_shift;
    logic [5:0]         glyph_advance;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;

    // model state
    metrics_t glyph_table [GLYPH_COUNT];
    bit       entry_loaded [GLYPH_COUNT];
    int       loaded_entries [$];
    int       font_height_cfg  = int'(FONT_HEIGHT_RESET);
    bit       advance_only_cfg = 1'b0;
    int       pen_x, pen_y, ext_left, ext_top, ext_bottom;
    int       max_advance, line_adv_peak, line_ink_peak, worst_overflow;
    box_t     expected_boxes [$];

    int       mismatch_count  = 0;
    int       boxes_checked   = 0;
    int       requests_sent   = 0;
    int       settings_used   = 0;
    bit       tx_burst        = 1'b0;
    bit       rx_steady       = 1'b0;
    int       rx_hold_cycles  = 0;
    int       rx_stall_left   = 0;

    text_bounding_box_measurer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .glyph_index   (glyph_index),
        .char_code     (char_code),
        .glyph_width   (glyph_width),
        .glyph_x_shift (glyph_x_shift),
        .glyph_y_shift (glyph_y_shift),
        .glyph_advance (glyph_advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_right     (box_right),
        .box_bottom    (box_bottom)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp_coord(input int v);
        int hi;
        int lo;
        hi = (1 << (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic void close_line();
        int ov;
        ov = clamp_coord(line_ink_peak - line_adv_peak);
        if (ov > worst_overflow)
        begin
            worst_overflow = ov;
        end
        line_adv_peak = 0;
        line_ink_peak = 0;
    endfunction

    function automatic void predict_measurement(
        input logic [1:0] m,
        input logic [6:0] gi,
        input logic [7:0] cc,
        input logic [5:0] w,
        input logic [5:0] xs,
        input logic [5:0] ys,
        input logic [5:0] adv
    );
        metrics_t g;
        int       xs_i, ys_i, w_i, adv_i, h, v;
        box_t     b;
        h = font_height_cfg;
        case (m)
            MODE_LOAD:
            begin
                if (gi < GLYPH_COUNT)
                begin
                    glyph_table[gi] = {adv, ys, xs, w};
                end
            end
            MODE_MEASURE:
            begin
                if (cc >= CHAR_FIRST && cc <= CHAR_LAST && int'(cc - CHAR_FIRST) < GLYPH_COUNT)
                begin
                    g     = glyph_table[7'(cc - CHAR_FIRST)];
                    xs_i  = int'(g.x_shift);
                    ys_i  = int'(g.y_shift);
                    w_i   = int'(g.width);
                    adv_i = int'(g.advance);
                    v = clamp_coord(pen_x + xs_i + w_i);
                    if (v > line_ink_peak) line_ink_peak = v;
                    v = clamp_coord(pen_y + ys_i + h);
                    if (v > ext_bottom) ext_bottom = v;
                    v = clamp_coord(pen_x + xs_i);
                    if (v < ext_left) ext_left = v;
                    v = clamp_coord(pen_y + ys_i);
                    if (v < ext_top) ext_top = v;
                    pen_x = clamp_coord(pen_x + xs_i + adv_i);
                    if (pen_x > max_advance) max_advance = pen_x;
                    if (pen_x > line_adv_peak) line_adv_peak = pen_x;
                end
                else if (cc == CHAR_NEWLINE)
                begin
                    pen_y = clamp_coord(pen_y + h + h / 4);
                    pen_x = 0;
                    if (ext_bottom < pen_y) ext_bottom = pen_y;
                    close_line();
                end
            end
            MODE_END:
            begin
                close_line();
                if (advance_only_cfg)
                begin
                    b.left  = '0;
                    b.right = 16'(max_advance);
                end
                else
                begin
                    b.left  = 16'(ext_left);
                    b.right = 16'(clamp_coord(max_advance + worst_overflow));
                end
                b.top    = 16'(ext_top);
                b.bottom = 16'(ext_bottom);
                expected_boxes.push_back(b);
                pen_x          = 0;
                pen_y          = 0;
                ext_left       = 0;
                ext_top        = 0;
                ext_bottom     = 0;
                max_advance    = 0;
                line_adv_peak  = 0;
                line_ink_peak  = 0;
                worst_overflow = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(
        input logic [1:0] m,
        input logic [6:0] gi,
        input logic [7:0] cc,
        input logic [5:0] w,
        input logic [5:0] xs,
        input logic [5:0] ys,
        input logic [5:0] adv
    );
        int gap;
        @(negedge clk);
        in_valid      <= 1'b1;
        mode          <= m;
        glyph_index   <= gi;
        char_code     <= cc;
        glyph_width   <= w;
        glyph_x_shift <= xs;
        glyph_y_shift <= ys;
        glyph_advance <= adv;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_measurement(m, gi, cc, w, xs, ys, adv);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_load(
        input int         gi,
        input logic [5:0] w,
        input logic [5:0] xs,
        input logic [5:0] ys,
        input logic [5:0] adv
    );
        send_request(MODE_LOAD, gi[6:0], 8'($urandom), w, xs, ys, adv);
        if (gi < GLYPH_COUNT && !entry_loaded[gi[6:0]])
        begin
            entry_loaded[gi[6:0]] = 1'b1;
            loaded_entries.push_back(gi);
        end
    endtask

    task automatic send_char(input logic [7:0] cc);
        send_request(MODE_MEASURE, 7'($urandom), cc, 6'($urandom), 6'($urandom),
                     6'($urandom), 6'($urandom));
    endtask

    task automatic send_end();
        send_request(MODE_END, 7'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
                     6'($urandom), 6'($urandom));
    endtask

    task automatic send_noop();
        send_request(MODE_UNUSED, 7'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
                     6'($urandom), 6'($urandom));
    endtask

    task automatic send_loaded_char();
        send_char(CHAR_FIRST + 8'(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]));
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_FONT_HEIGHT)
        begin
            font_height_cfg = int'(data);
        end
        else
        begin
            advance_only_cfg = data[0];
        end
    endtask

    task automatic apply_setting(input logic [7:0] height, input logic ignore);
        wait_idle();
        write_reg(CFG_FONT_HEIGHT, height);
        write_reg(CFG_ADVANCE_ONLY, {7'd0, ignore});
        settings_used++;
    endtask

    task automatic send_random_string();
        int          len, k, r;
        int unsigned c;
        r   = $urandom_range(0, 9);
        len = (r < 8) ? $urandom_range(0, 12) : $urandom_range(13, 40);
        for (k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6 || loaded_entries.size() == 0)
            begin
                send_load($urandom_range(0, 127), 6'($urandom), 6'($urandom), 6'($urandom),
                          6'($urandom));
            end
            else if (r < 16)
            begin
                send_char(CHAR_NEWLINE);
            end
            else if (r < 22)
            begin
                do
                begin
                    c = $urandom_range(0, 255);
                end
                while (c == CHAR_NEWLINE || (c >= CHAR_FIRST && c <= CHAR_LAST));
                send_char(8'(c));
            end
            else if (r < 25)
            begin
                send_noop();
            end
            else
            begin
                send_loaded_char();
            end
        end
        send_end();
        // sometimes hold the sender until every box is back
        if ($urandom_range(0, 7) == 0)
        begin
            wait_results();
        end
    endtask

    task automatic test_directed();
        send_load(0, 6'd0, 6'd0, 6'd0, 6'd0);
        send_load(94, 6'd63, 6'sd31, 6'sd31, 6'd63);
        send_load(33, 6'd0, -6'sd32, -6'sd32, 6'd0);
        send_load(65, 6'd5, -6'sd3, 6'sd2, 6'd7);
        send_load(95, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
        send_load(127, 6'd63, 6'h3f, 6'h3f, 6'd63);
        send_end();
        send_char(8'd32);
        send_char(8'd126);
        send_char(8'd65);
        send_char(8'd97);
        send_char(CHAR_NEWLINE);
        send_char(8'd0);
        send_char(8'd9);
        send_char(8'd127);
        send_char(8'd255);
        send_char(8'd200);
        send_noop();
        send_end();
        send_char(CHAR_NEWLINE);
        send_char(8'd126);
        send_char(CHAR_NEWLINE);
        send_char(8'd97);
        send_end();
    endtask

    task automatic test_saturation();
        int k;
        apply_setting(8'd255, 1'b0);
        send_load(94, 6'd63, 6'sd31, 6'sd31, 6'd63);
        for (k = 0; k < 352; k++)
        begin
            send_char(8'd126);
        end
        for (k = 0; k < 106; k++)
        begin
            send_char(CHAR_NEWLINE);
        end
        send_char(8'd126);
        send_end();
    endtask

    task automatic test_output_hold();
        int k;
        wait_idle();
        tx_burst       = 1'b1;
        rx_hold_cycles = 80;
        for (k = 0; k < 30; k++)
        begin
            if (k % 3 == 2)
            begin
                send_end();
            end
            else
            begin
                send_loaded_char();
            end
        end
        tx_burst = 1'b0;
        wait_results();
    endtask

    task automatic test_settings_sweep();
        logic [7:0] heights [SETTING_COUNT] = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd200, 8'd7};
        logic       ignores [SETTING_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        int         p, start;
        for (p = 0; p < SETTING_COUNT; p++)
        begin
            apply_setting(heights[p], ignores[p]);
            // first phase runs with no idling on either side
            tx_burst  = (p == 0);
            rx_steady = (p == 0);
            start     = requests_sent;
            while (requests_sent - start < PHASE_REQUESTS)
            begin
                send_random_string();
            end
        end
        tx_burst  = 1'b0;
        rx_steady = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        box_t exp_box;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected box %0d %0d %0d %0d", $realtime,
                             box_left, box_top, box_right, box_bottom);
                end
            end
            else
            begin
                exp_box = expected_boxes.pop_front();
                boxes_checked++;
                if (box_left !== exp_box.left || box_top !== exp_box.top ||
                    box_right !== exp_box.right || box_bottom !== exp_box.bottom)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: box mismatch exp l=%0d t=%0d r=%0d b=%0d got l=%0d t=%0d r=%0d b=%0d",
                                 $realtime, exp_box.left, exp_box.top, exp_box.right,
                                 exp_box.bottom, box_left, box_top, box_right, box_bottom);
                    end
                end
            end
        end
    end

    // output side stalls
    initial
    begin
        int r;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else if (rx_steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready     <= 1'b0;
                    rx_stall_left  = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 30);
                end
            end
        end
    end

    initial
    begin
        #(CLK_PERIOD * 1000000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = 8'd0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        glyph_index   = 7'd0;
        char_code     = 8'd0;
        glyph_width   = 6'd0;
        glyph_x_shift = 6'sd0;
        glyph_y_shift = 6'sd0;
        glyph_advance = 6'd0;
        pen_x          = 0;
        pen_y          = 0;
        ext_left       = 0;
        ext_top        = 0;
        ext_bottom     = 0;
        max_advance    = 0;
        line_adv_peak  = 0;
        line_ink_peak  = 0;
        worst_overflow = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_saturation();
        test_output_hold();
        test_settings_sweep();
        wait_idle();

        $display("covered %0d requests, %0d boxes checked, %0d register settings",
                 requests_sent, boxes_checked, settings_used);
        $display("including saturation, ignored codes, unused mode and a long output hold");
        if (mismatch_count == 0 && expected_boxes.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
